>>> rtl/core/bounded_array_list_engine_top_defines.svh
`ifndef BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded list check failed");

// Next-cycle implication, checked outside reset.
`define BAL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bounded list check failed");

`endif

>>> rtl/core/bal_pkg.sv
`timescale 1ns / 1ps

package bal_pkg;

  localparam int CAPACITY   = 128;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int LEN_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int CNT_W      = 8;
  localparam int CMP_W      = (LEN_W > POS_W) ? LEN_W : POS_W;

  typedef enum logic [2:0] {
    K_APPEND       = 3'd0,
    K_INSERT       = 3'd1,
    K_REMOVE_AT    = 3'd2,
    K_REMOVE_VALUE = 3'd3,
    K_REMOVE_ALL   = 3'd4,
    K_CLEAR        = 3'd5,
    K_UPDATE       = 3'd6,
    K_READ         = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic    load;
    logic    set_status;
    status_t set_code;
    logic    append;
    logic    write_pos;
    logic    len_inc;
    logic    read_pos;
    logic    take_read;
    logic    clear_list;
    logic    shift_start;
    logic    shift_step;
    logic    compact_start;
    logic    compact_step;
    logic    publish;
  } bal_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  idx_beyond;
    logic  idx_not_below;
    logic  full;
    logic  shift_last;
    logic  compact_done;
    logic  out_free;
  } bal_stat_t;

endpackage

>>> rtl/core/bal_ram.sv
`timescale 1ns / 1ps

module bal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bal_controller.sv
`timescale 1ns / 1ps

module bal_controller import bal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  bal_stat_t stat,
  output bal_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_INS_WRITE,
    S_COMPACT,
    S_READ_WAIT,
    S_FINISH
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (stat.kind) inside
          K_APPEND: begin
            if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_FULL;
            end else begin
              cmd.append  = 1'b1;
              cmd.len_inc = 1'b1;
            end
          end
          K_INSERT: begin
            if (stat.idx_beyond) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_BAD_INDEX;
            end else if (stat.full) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_FULL;
            end else if (stat.idx_not_below) begin
              cmd.append  = 1'b1;
              cmd.len_inc = 1'b1;
            end else begin
              cmd.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end
          end
          K_REMOVE_AT: begin
            if (stat.idx_not_below) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_BAD_INDEX;
            end else begin
              cmd.compact_start = 1'b1;
              state_next        = S_COMPACT;
            end
          end
          K_REMOVE_VALUE, K_REMOVE_ALL: begin
            cmd.compact_start = 1'b1;
            state_next        = S_COMPACT;
          end
          K_CLEAR: begin
            cmd.clear_list = 1'b1;
          end
          K_UPDATE: begin
            if (stat.idx_not_below) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_BAD_INDEX;
            end else begin
              cmd.write_pos = 1'b1;
            end
          end
          K_READ: begin
            if (stat.idx_not_below) begin
              cmd.set_status = 1'b1;
              cmd.set_code   = ST_BAD_INDEX;
            end else begin
              cmd.read_pos = 1'b1;
              state_next   = S_READ_WAIT;
            end
          end
        endcase
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_last) begin
          state_next = S_INS_WRITE;
        end
      end
      S_INS_WRITE: begin
        cmd.write_pos = 1'b1;
        cmd.len_inc   = 1'b1;
        state_next    = S_FINISH;
      end
      S_COMPACT: begin
        cmd.compact_step = 1'b1;
        if (stat.compact_done) begin
          state_next = S_FINISH;
        end
      end
      S_READ_WAIT: begin
        cmd.take_read = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> rtl/core/bal_datapath.sv
`timescale 1ns / 1ps

module bal_datapath import bal_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  bal_cmd_t                cmd,
  output bal_stat_t               stat,
  input  logic [2:0]              kind,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] read_data,
  output logic [CNT_W-1:0]        new_length,
  output logic [CNT_W-1:0]        removed_count
);

  kind_t                 cmd_kind;
  logic [POS_W-1:0]      cmd_pos;
  logic [DATA_WIDTH-1:0] cmd_val;
  logic [LEN_W-1:0]      len;
  logic [LEN_W-1:0]      rd_ptr;
  logic [LEN_W-1:0]      wr_ptr;
  logic [LEN_W-1:0]      removed;
  logic                  pend;
  logic [IDX_W-1:0]      pend_addr;
  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_data;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [CMP_W-1:0]      pos_c;
  logic [CMP_W-1:0]      len_c;
  logic [IDX_W-1:0]      pos_idx;
  logic [LEN_W-1:0]      len_dn;
  logic [LEN_W-1:0]      rd_up;
  logic [LEN_W-1:0]      rd_dn;
  logic                  scan_more;
  logic                  drop;
  logic                  counted_kind;

  bal_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign pos_c        = CMP_W'(cmd_pos);
  assign len_c        = CMP_W'(len);
  assign pos_idx      = IDX_W'(cmd_pos);
  assign len_dn       = len - LEN_W'(1);
  assign rd_up        = rd_ptr + LEN_W'(1);
  assign rd_dn        = rd_ptr - LEN_W'(1);
  assign scan_more    = (rd_ptr != len);
  assign counted_kind = (cmd_kind == K_REMOVE_VALUE) || (cmd_kind == K_REMOVE_ALL);

  // In a compaction pass an entry is dropped when it is the addressed one, or when it
  // matches the value (only the first match for a single-value removal).
  always_comb begin
    if (cmd_kind == K_REMOVE_AT) begin
      drop = pend && (pend_addr == pos_idx);
    end else begin
      drop = pend && (ram_rdata == cmd_val) &&
             ((cmd_kind == K_REMOVE_ALL) || (removed == '0));
    end
  end

  always_comb begin
    stat.kind          = cmd_kind;
    stat.idx_beyond    = (pos_c > len_c);
    stat.idx_not_below = (pos_c >= len_c);
    stat.full          = (len == LEN_W'(CAPACITY));
    stat.shift_last    = (CMP_W'(rd_ptr) == pos_c);
    stat.compact_done  = !pend && !scan_more;
    stat.out_free      = !out_valid || out_ready;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = cmd_val;
    if (cmd.append) begin
      ram_we    = 1'b1;
      ram_waddr = len[IDX_W-1:0];
    end else if (cmd.write_pos) begin
      ram_we    = 1'b1;
      ram_waddr = pos_idx;
    end else if (cmd.shift_step) begin
      ram_we    = 1'b1;
      ram_waddr = rd_up[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end else if (cmd.compact_step && pend && !drop) begin
      ram_we    = 1'b1;
      ram_waddr = wr_ptr[IDX_W-1:0];
      ram_wdata = ram_rdata;
    end
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (cmd.read_pos) begin
      ram_re    = 1'b1;
      ram_raddr = pos_idx;
    end else if (cmd.shift_start) begin
      ram_re    = 1'b1;
      ram_raddr = len_dn[IDX_W-1:0];
    end else if (cmd.shift_step && !stat.shift_last) begin
      ram_re    = 1'b1;
      ram_raddr = rd_dn[IDX_W-1:0];
    end else if (cmd.compact_step && scan_more) begin
      ram_re    = 1'b1;
      ram_raddr = rd_ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_list) begin
        len <= '0;
      end else if (cmd.len_inc) begin
        len <= len + LEN_W'(1);
      end else if (cmd.compact_step && stat.compact_done) begin
        len <= wr_ptr;
      end
      if (cmd.compact_start) begin
        pend <= 1'b0;
      end else if (cmd.compact_step) begin
        pend <= scan_more;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_kind   <= kind_t'(kind);
      cmd_pos    <= position;
      cmd_val    <= DATA_WIDTH'(item_value);
      res_status <= ST_OK;
      res_data   <= '0;
      removed    <= '0;
    end
    if (cmd.set_status) begin
      res_status <= cmd.set_code;
    end
    if (cmd.take_read) begin
      res_data <= ram_rdata;
    end
    if (cmd.shift_start) begin
      rd_ptr <= len_dn;
    end
    if (cmd.shift_step && !stat.shift_last) begin
      rd_ptr <= rd_dn;
    end
    if (cmd.compact_start) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
    end
    if (cmd.compact_step) begin
      if (pend) begin
        if (drop) begin
          removed <= removed + LEN_W'(1);
        end else begin
          wr_ptr <= wr_ptr + LEN_W'(1);
        end
      end
      if (scan_more) begin
        rd_ptr    <= rd_up;
        pend_addr <= rd_ptr[IDX_W-1:0];
      end
      if (stat.compact_done) begin
        res_status <= ((removed == '0) && counted_kind) ? ST_NOT_FOUND : ST_OK;
      end
    end
    if (cmd.publish) begin
      status        <= res_status;
      read_data     <= VAL_W'(res_data);
      new_length    <= CNT_W'(len);
      removed_count <= counted_kind ? CNT_W'(removed) : '0;
    end
  end

endmodule

>>> rtl/core/bounded_array_list_engine_top.sv
`timescale 1ns / 1ps

// Bounded array list engine. Each command arrives on the input channel (in_valid,
// in_ready, kind, position, item_value) and yields exactly one result transfer on the
// output channel (out_valid, out_ready, status, read_data, new_length, removed_count).
// One command is in progress at a time; in_ready is high only while the engine is idle.
// Append, clear, update and any rejected command go from decode straight to the finish
// state. A read passes through a wait state, as the store read is registered. Insert at
// an index below the list length first shifts the entries above it up, then writes.
// The remove commands sweep the whole list once through the entry store, one entry
// read and at most one written per cycle; insert walks the entries above the index
// the same way.
// The result sits in an output register. If the receiver stalls, the engine finishes the
// next command and holds in its final state until the register frees up.
// Reset empties the list and drops any pending result; entry contents are not cleared.

module bounded_array_list_engine_top import bal_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              kind,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic signed [VAL_W-1:0] read_data,
  output logic [CNT_W-1:0]        new_length,
  output logic [CNT_W-1:0]        removed_count
);

  bal_cmd_t  cmd;
  bal_stat_t stat;

  bal_controller u_controller (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  bal_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .position     (position),
    .item_value   (item_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .read_data    (read_data),
    .new_length   (new_length),
    .removed_count(removed_count)
  );

endmodule

>>> rtl/core/bal_checker.sv
`timescale 1ns / 1ps
`include "bounded_array_list_engine_top_defines.svh"

module bal_checker import bal_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              status,
  input logic signed [VAL_W-1:0] read_data,
  input logic [CNT_W-1:0]        new_length,
  input logic [CNT_W-1:0]        removed_count
);

  `BAL_ASSERT_NOW(a_len_bound, out_valid, 32'(new_length) <= CAPACITY)
  `BAL_ASSERT_NOW(a_err_no_data, out_valid && (status != ST_OK), read_data == '0)
  `BAL_ASSERT_NOW(a_removed_ok, out_valid && (removed_count != '0), status == ST_OK)
  `BAL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `BAL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_length))

endmodule

bind bounded_array_list_engine_top bal_checker u_checker (.*);
